@@ rtl/pps_pkg.sv @@
// Package for the preemptive priority scheduler: payload structs, the
// controller/datapath command and status structs, and the function and status codes.
// No dependencies.
package pps_pkg;

  // Function codes of an input item.
  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Status codes of a result item.
  localparam logic [2:0] STAT_IDLE_TICK = 3'd0;
  localparam logic [2:0] STAT_RAN       = 3'd1;
  localparam logic [2:0] STAT_DONE      = 3'd2;
  localparam logic [2:0] STAT_ADMIT     = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;

  localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic        func;
    logic [7:0]  task_id;
    logic [7:0]  task_priority;
    logic [15:0] burst_length;
    logic [31:0] arrival_time;
  } pps_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] time_now;
    logic [7:0]  running_id;
    logic [7:0]  running_priority;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [47:0] total_turnaround;
    logic [47:0] total_waiting;
    logic [15:0] completed_tasks;
  } pps_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the accepted item and restart the slot scan
    logic scan;      // examine one slot and advance the scan index
    logic turn;      // compute the turnaround of the selected task
    logic wait_calc; // compute the waiting time from the turnaround
    logic commit;    // update the state and load the result register
  } pps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic scan_last;
  } pps_stat_t;

endpackage

@@ rtl/pps_ctrl.sv @@
// Controller of the preemptive priority scheduler: sequences admit and tick
// items and owns the result-channel valid. Depends on pps_pkg.
module pps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pps_pkg::pps_stat_t  stat,
  output pps_pkg::pps_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TURN,
    ST_WAIT,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_room;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);
  // The result register can take a new result when it is empty or being drained.
  assign out_room  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_COMMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_TURN;
        end
      end
      ST_TURN: begin
        cmd.turn  = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        cmd.wait_calc = 1'b1;
        state_nxt     = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_room) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A tick item goes through the slot scan before it commits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_COMMIT && !cmd.commit) begin
        state_r <= ST_COMMIT;
      end else if (state_r == ST_IDLE && accept && stat.is_tick) begin
        state_r <= ST_SCAN;
      end else begin
        state_r <= state_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result committed over an undelivered result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted item did not start processing");

  a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result valid rose without a commit");
`endif

endmodule

@@ rtl/pps_datapath.sv @@
// Datapath of the preemptive priority scheduler: task slot table, slot scan,
// time counter, completion statistics and result register. Depends on pps_pkg.
module pps_datapath #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pps_pkg::pps_in_t    in_data,
  input  pps_pkg::pps_cmd_t   cmd,
  output pps_pkg::pps_stat_t  stat,
  output pps_pkg::pps_out_t   out_data
);

  localparam int IDXW = $clog2(SLOTS);

  // Slot table; payload entries are meaningful only while the slot is valid.
  logic [SLOTS-1:0] valid_r;
  logic [7:0]       slot_id_r    [SLOTS];
  logic [7:0]       slot_pri_r   [SLOTS];
  logic [15:0]      slot_rem_r   [SLOTS];
  logic [31:0]      slot_arr_r   [SLOTS];
  logic [15:0]      slot_burst_r [SLOTS];

  pps_pkg::pps_in_t  item_r;
  pps_pkg::pps_out_t out_r, out_nxt;

  logic [IDXW-1:0] idx_r;
  logic            found_r;
  logic [IDXW-1:0] best_idx_r;
  logic [7:0]      best_id_r;
  logic [7:0]      best_pri_r;
  logic [15:0]     best_rem_r;
  logic [31:0]     best_arr_r;
  logic [15:0]     best_burst_r;
  logic [31:0]     turn_r;
  logic [31:0]     wait_r;

  logic [31:0] time_r;
  logic [15:0] count_r;
  logic [47:0] sum_tat_r;
  logic [47:0] sum_wt_r;

  logic            free_found;
  logic [IDXW-1:0] free_idx;
  logic            better;
  logic            is_tick;
  logic            retire;
  logic [48:0]     tat_add;
  logic [48:0]     wt_add;
  logic [47:0]     sum_tat_nxt;
  logic [47:0]     sum_wt_nxt;
  logic [15:0]     count_nxt;

  assign is_tick        = (item_r.func == pps_pkg::FUNC_TICK);
  assign stat.is_tick   = (in_data.func == pps_pkg::FUNC_TICK);
  assign stat.scan_last = (idx_r == IDXW'(SLOTS - 1));
  assign out_data       = out_r;

  // Lowest free slot for an admit.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDXW'(i);
      end
    end
  end

  // Strictly smaller priority wins, so ties stay with the lower slot.
  assign better = valid_r[idx_r] && (!found_r || (slot_pri_r[idx_r] < best_pri_r));

  assign retire      = found_r && (best_rem_r <= 16'd1);
  assign tat_add     = {1'b0, sum_tat_r} + 49'(turn_r);
  assign wt_add      = {1'b0, sum_wt_r} + 49'(wait_r);
  assign sum_tat_nxt = tat_add[48] ? pps_pkg::SUM_MAX : tat_add[47:0];
  assign sum_wt_nxt  = wt_add[48] ? pps_pkg::SUM_MAX : wt_add[47:0];
  assign count_nxt   = (count_r == pps_pkg::COUNT_MAX) ? count_r : count_r + 16'd1;

  always_comb begin
    out_nxt                  = '0;
    out_nxt.time_now         = time_r;
    out_nxt.total_turnaround = sum_tat_r;
    out_nxt.total_waiting    = sum_wt_r;
    out_nxt.completed_tasks  = count_r;
    if (!is_tick) begin
      out_nxt.status = free_found ? pps_pkg::STAT_ADMIT : pps_pkg::STAT_FULL;
    end else if (!found_r) begin
      out_nxt.status = pps_pkg::STAT_IDLE_TICK;
    end else begin
      out_nxt.running_id       = best_id_r;
      out_nxt.running_priority = best_pri_r;
      if (retire) begin
        out_nxt.status           = pps_pkg::STAT_DONE;
        out_nxt.turnaround       = turn_r;
        out_nxt.waiting          = wait_r;
        out_nxt.total_turnaround = sum_tat_nxt;
        out_nxt.total_waiting    = sum_wt_nxt;
        out_nxt.completed_tasks  = count_nxt;
      end else begin
        out_nxt.status = pps_pkg::STAT_RAN;
      end
    end
  end

  // Control and statistics state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      time_r    <= '0;
      count_r   <= '0;
      sum_tat_r <= '0;
      sum_wt_r  <= '0;
      found_r   <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (cmd.capture) begin
        found_r <= 1'b0;
        idx_r   <= '0;
      end else if (cmd.scan) begin
        idx_r <= idx_r + IDXW'(1);
        if (better) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (!is_tick) begin
          if (free_found) begin
            valid_r[free_idx] <= 1'b1;
          end
        end else begin
          time_r <= time_r + 32'd1;
          if (retire) begin
            valid_r[best_idx_r] <= 1'b0;
            sum_tat_r           <= sum_tat_nxt;
            sum_wt_r            <= sum_wt_nxt;
            count_r             <= count_nxt;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.scan && better) begin
      best_idx_r   <= idx_r;
      best_id_r    <= slot_id_r[idx_r];
      best_pri_r   <= slot_pri_r[idx_r];
      best_rem_r   <= slot_rem_r[idx_r];
      best_arr_r   <= slot_arr_r[idx_r];
      best_burst_r <= slot_burst_r[idx_r];
    end
    if (cmd.turn) begin
      turn_r <= time_r + 32'd1 - best_arr_r;
    end
    if (cmd.wait_calc) begin
      wait_r <= (turn_r > 32'(best_burst_r)) ? turn_r - 32'(best_burst_r) : 32'd0;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
      if (!is_tick && free_found) begin
        slot_id_r[free_idx]    <= item_r.task_id;
        slot_pri_r[free_idx]   <= item_r.task_priority;
        slot_rem_r[free_idx]   <= item_r.burst_length;
        slot_arr_r[free_idx]   <= item_r.arrival_time;
        slot_burst_r[free_idx] <= item_r.burst_length;
      end else if (is_tick && found_r && !retire) begin
        slot_rem_r[best_idx_r] <= best_rem_r - 16'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_tick_advances_time: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_tick) |=> (time_r == $past(time_r) + 32'd1))
    else $error("tick did not advance the time counter");

  a_admit_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !is_tick) |=> $stable(time_r))
    else $error("admit changed the time counter");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (count_r >= $past(count_r)))
    else $error("completed count decreased");
`endif

endmodule

@@ rtl/preemptive_priority_scheduler_core.sv @@
// Sequence: an admit goes straight to commit; a tick first scans the slot table
// one slot per cycle, then computes the turnaround and the waiting time, then
// commits. An item commits only when the result register has room, and no new
// item is taken before it commits. The next item is taken while a result waits.
// Reset (synchronous, rst_n low) empties all slots and clears the time
// counter and completion statistics.
module preemptive_priority_scheduler_core #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pps_pkg::pps_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::pps_out_t  out_data
);

  pps_pkg::pps_cmd_t  cmd;
  pps_pkg::pps_stat_t stat;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pps_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
